@@ src/ico_pkg.sv @@
// Shared types, constants and lookup tables of the icosphere face tessellator.
package ico_pkg;

    localparam int FACE_COUNT = 20;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 104;

    // Corner coordinates of the unit icosahedron, 30 fraction bits
    localparam longint X_Q30 = 64'sd564499483;
    localparam longint Z_Q30 = 64'sd913379351;

    typedef enum logic [2:0] {
        CC_ZERO,
        CC_POS_X,
        CC_NEG_X,
        CC_POS_Z,
        CC_NEG_Z
    } corner_t;

    // Vertex slots of one subdivision level: parent corners, then edge midpoints
    typedef enum logic [2:0] {
        SL_P0,
        SL_P1,
        SL_P2,
        SL_M0,
        SL_M1,
        SL_M2
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MID_START,
        ST_MID_WAIT,
        ST_COPY,
        ST_EMIT_CALC,
        ST_EMIT_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_SQUARE,
        MP_SQRT,
        MP_DIV_INIT,
        MP_DIV,
        MP_DONE
    } mid_phase_t;

    typedef struct packed {
        logic       load_in;
        logic       load_corners;
        logic       mid_start;
        logic       mid_store;
        logic       mid_lvl;
        logic [1:0] mid_pair;
        logic       copy_v;
        logic       emit_calc;
        logic       emit_out;
        logic       last;
        logic [1:0] depth;
        logic [1:0] child_k;
        logic [1:0] child_j;
        logic [1:0] vtx_pos;
        logic [1:0] comp;
    } ico_cmd_t;

    typedef struct packed {
        logic face_ok;
        logic mid_done;
        logic out_free;
    } ico_stat_t;

    function automatic corner_t corner_code(input logic [3:0] idx, input logic [1:0] comp);
        corner_t c0;
        corner_t c1;
        corner_t c2;
        c0 = CC_ZERO;
        c1 = CC_ZERO;
        c2 = CC_ZERO;
        case (idx)
            4'd0:    begin c0 = CC_NEG_X; c1 = CC_ZERO;  c2 = CC_POS_Z; end
            4'd1:    begin c0 = CC_POS_X; c1 = CC_ZERO;  c2 = CC_POS_Z; end
            4'd2:    begin c0 = CC_NEG_X; c1 = CC_ZERO;  c2 = CC_NEG_Z; end
            4'd3:    begin c0 = CC_POS_X; c1 = CC_ZERO;  c2 = CC_NEG_Z; end
            4'd4:    begin c0 = CC_ZERO;  c1 = CC_POS_Z; c2 = CC_POS_X; end
            4'd5:    begin c0 = CC_ZERO;  c1 = CC_POS_Z; c2 = CC_NEG_X; end
            4'd6:    begin c0 = CC_ZERO;  c1 = CC_NEG_Z; c2 = CC_POS_X; end
            4'd7:    begin c0 = CC_ZERO;  c1 = CC_NEG_Z; c2 = CC_NEG_X; end
            4'd8:    begin c0 = CC_POS_Z; c1 = CC_POS_X; c2 = CC_ZERO;  end
            4'd9:    begin c0 = CC_NEG_Z; c1 = CC_POS_X; c2 = CC_ZERO;  end
            4'd10:   begin c0 = CC_POS_Z; c1 = CC_NEG_X; c2 = CC_ZERO;  end
            4'd11:   begin c0 = CC_NEG_Z; c1 = CC_NEG_X; c2 = CC_ZERO;  end
            default: begin c0 = CC_ZERO;  c1 = CC_ZERO;  c2 = CC_ZERO;  end
        endcase
        case (comp)
            2'd0:    return c0;
            2'd1:    return c1;
            default: return c2;
        endcase
    endfunction

    // Corner indexes of a face; element 0 is the last entry of each table row
    function automatic logic [2:0][3:0] face_row(input logic [4:0] face);
        logic [2:0][3:0] r;
        case (face)
            5'd0:    r = {4'd1,  4'd4,  4'd0};
            5'd1:    r = {4'd4,  4'd9,  4'd0};
            5'd2:    r = {4'd4,  4'd5,  4'd9};
            5'd3:    r = {4'd8,  4'd5,  4'd4};
            5'd4:    r = {4'd1,  4'd8,  4'd4};
            5'd5:    r = {4'd1,  4'd10, 4'd8};
            5'd6:    r = {4'd10, 4'd3,  4'd8};
            5'd7:    r = {4'd8,  4'd3,  4'd5};
            5'd8:    r = {4'd3,  4'd2,  4'd5};
            5'd9:    r = {4'd3,  4'd7,  4'd2};
            5'd10:   r = {4'd3,  4'd10, 4'd7};
            5'd11:   r = {4'd10, 4'd6,  4'd7};
            5'd12:   r = {4'd6,  4'd11, 4'd7};
            5'd13:   r = {4'd6,  4'd0,  4'd11};
            5'd14:   r = {4'd6,  4'd1,  4'd0};
            5'd15:   r = {4'd10, 4'd1,  4'd6};
            5'd16:   r = {4'd11, 4'd0,  4'd9};
            5'd17:   r = {4'd2,  4'd11, 4'd9};
            5'd18:   r = {4'd5,  4'd2,  4'd9};
            5'd19:   r = {4'd11, 4'd2,  4'd7};
            default: r = {4'd0,  4'd0,  4'd0};
        endcase
        return r;
    endfunction

    // Child triangles: (a,ab,ac), (b,bc,ab), (c,ac,bc), (ab,bc,ac)
    function automatic slot_t child_slot(input logic [1:0] child, input logic [1:0] pos);
        slot_t s0;
        slot_t s1;
        slot_t s2;
        case (child)
            2'd0:    begin s0 = SL_P0; s1 = SL_M0; s2 = SL_M1; end
            2'd1:    begin s0 = SL_P1; s1 = SL_M2; s2 = SL_M0; end
            2'd2:    begin s0 = SL_P2; s1 = SL_M1; s2 = SL_M2; end
            default: begin s0 = SL_M0; s1 = SL_M2; s2 = SL_M1; end
        endcase
        case (pos)
            2'd0:    return s0;
            2'd1:    return s1;
            default: return s2;
        endcase
    endfunction

endpackage

@@ src/ico_mid.sv @@
// Iterative edge midpoint unit: sum, squared length, integer square root, three dividers.
module ico_mid #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2:0][FRAC_BITS+1:0]     a,
    input  logic [2:0][FRAC_BITS+1:0]     b,
    output logic                          done,
    output logic [2:0][FRAC_BITS+1:0]     res
);

    localparam int VW   = FRAC_BITS + 2;
    localparam int SUMW = FRAC_BITS + 3;
    localparam int MW   = FRAC_BITS + 2;
    localparam int SW   = 2 * FRAC_BITS + 6;
    localparam int LW   = FRAC_BITS + 3;
    localparam int QB   = FRAC_BITS + 1;
    localparam int CW   = $clog2(SW / 2);

    ico_pkg::mid_phase_t     phase_reg, phase_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [2:0][SUMW-1:0]    sum_reg, sum_next;
    logic [SW-1:0]           s_reg, s_next;
    logic [SW-1:0]           r_reg, r_next;
    logic [SW-1:0]           bit_reg, bit_next;
    logic [2:0][SW-1:0]      num_reg, num_next;
    logic [SW-1:0]           den_reg, den_next;
    logic [2:0][QB-1:0]      q_reg, q_next;
    logic [2:0]              neg_reg, neg_next;
    logic                    zero_reg, zero_next;

    logic [2:0][MW-1:0]      mag;
    logic [MW-1:0]           sq_in;
    logic [2*MW-1:0]         sq;
    logic [SW-1:0]           trial;
    logic [LW-1:0]           len;
    logic [VW-1:0]           qe;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = sum_reg[i][SUMW-1] ? MW'(-sum_reg[i]) : MW'(sum_reg[i]);
        end
        case (cnt_reg[1:0])
            2'd0:    sq_in = mag[0];
            2'd1:    sq_in = mag[1];
            default: sq_in = mag[2];
        endcase
        sq    = sq_in * sq_in;
        trial = r_reg + bit_reg;
        len   = r_reg[LW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            qe = VW'(q_reg[i]);
            if (zero_reg)
                res[i] = '0;
            else if (neg_reg[i])
                res[i] = -qe;
            else
                res[i] = qe;
        end
    end

    assign done = (phase_reg == ico_pkg::MP_DONE);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        case (phase_reg)
            ico_pkg::MP_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_next[i] = {a[i][VW-1], a[i]} + {b[i][VW-1], b[i]};
                    end
                    s_next     = '0;
                    cnt_next   = '0;
                    phase_next = ico_pkg::MP_SQUARE;
                end
            end
            ico_pkg::MP_SQUARE:
            begin
                s_next = s_reg + SW'(sq);
                if (cnt_reg == CW'(2))
                begin
                    cnt_next   = '0;
                    r_next     = '0;
                    bit_next   = SW'(1) << (SW - 2);
                    phase_next = ico_pkg::MP_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ico_pkg::MP_SQRT:
            begin
                if (s_reg >= trial)
                begin
                    s_next = s_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == CW'(SW / 2 - 1))
                begin
                    cnt_next   = '0;
                    phase_next = ico_pkg::MP_DIV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ico_pkg::MP_DIV_INIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_next[i] = (SW'(mag[i]) << (FRAC_BITS + 1)) + SW'(len);
                    neg_next[i] = sum_reg[i][SUMW-1];
                end
                // divisor 2*len aligned to the top quotient bit
                den_next   = SW'(len) << QB;
                q_next     = '0;
                zero_next  = (len == '0);
                cnt_next   = '0;
                phase_next = ico_pkg::MP_DIV;
            end
            ico_pkg::MP_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (num_reg[i] >= den_reg)
                    begin
                        num_next[i] = num_reg[i] - den_reg;
                        q_next[i]   = {q_reg[i][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        q_next[i] = {q_reg[i][QB-2:0], 1'b0};
                    end
                end
                den_next = den_reg >> 1;
                if (cnt_reg == CW'(QB - 1))
                begin
                    cnt_next   = '0;
                    phase_next = ico_pkg::MP_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ico_pkg::MP_DONE:
            begin
                phase_next = ico_pkg::MP_IDLE;
            end
            default:
            begin
                phase_next = ico_pkg::MP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ico_pkg::MP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        s_reg    <= s_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

endmodule

@@ src/ico_dp.sv @@
// Datapath: vertex registers, corner lookup, midpoint unit, vertex scaling and output register.
module ico_dp #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ico_pkg::IN_W-1:0]    in_data,
    input  ico_pkg::ico_cmd_t           cmd,
    output ico_pkg::ico_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ico_pkg::OUT_W-1:0]   out_data,
    output logic                        out_last
);

    localparam int VW    = FRAC_BITS + 2;
    localparam int MAGW  = FRAC_BITS + 1;
    localparam int PRW   = FRAC_BITS + 17;
    localparam int NWW   = FRAC_BITS + 16;
    localparam int NSH_R = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 1;
    localparam int NSH_L = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam longint X_F = (ico_pkg::X_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint Z_F = (ico_pkg::Z_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic [VW-1:0] XV = VW'(X_F);
    localparam logic [VW-1:0] ZV = VW'(Z_F);

    typedef logic [2:0][VW-1:0] vec_t;

    logic [4:0]        face_reg;
    logic [15:0]       radius_reg;
    vec_t              w0_reg, w1_reg, w2_reg, m0_reg, m1_reg, m2_reg;
    vec_t              v0_reg, v1_reg, v2_reg, n0_reg, n1_reg, n2_reg;
    logic [2:0][15:0]  nrm_reg;
    logic [2:0][17:0]  pos_reg;
    logic              out_valid_reg;
    logic [ico_pkg::OUT_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [2:0][3:0]   row;
    vec_t              c0, c1, c2;
    vec_t              mid_a, mid_b, mid_res;
    logic              mid_done;
    vec_t              emit_vec;
    ico_pkg::slot_t    leaf_slot;
    logic [VW-1:0]     comp_val;
    logic              neg;
    logic [MAGW-1:0]   mag;
    logic [NWW-1:0]    nwide;
    logic [15:0]       nq;
    logic [PRW-1:0]    prod;
    logic [PRW-1:0]    rsh;
    logic [16:0]       sat;
    logic [17:0]       pq;

    function automatic logic [VW-1:0] code_val(input ico_pkg::corner_t c);
        case (c)
            ico_pkg::CC_POS_X: return XV;
            ico_pkg::CC_NEG_X: return -XV;
            ico_pkg::CC_POS_Z: return ZV;
            ico_pkg::CC_NEG_Z: return -ZV;
            default:           return '0;
        endcase
    endfunction

    function automatic vec_t corner_vec(input logic [3:0] idx);
        vec_t v;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = code_val(ico_pkg::corner_code(idx, 2'(i)));
        end
        return v;
    endfunction

    function automatic vec_t pick(input ico_pkg::slot_t s, input vec_t p0, input vec_t p1,
                                  input vec_t p2, input vec_t q0, input vec_t q1,
                                  input vec_t q2);
        case (s)
            ico_pkg::SL_P0: return p0;
            ico_pkg::SL_P1: return p1;
            ico_pkg::SL_P2: return p2;
            ico_pkg::SL_M0: return q0;
            ico_pkg::SL_M1: return q1;
            default:        return q2;
        endcase
    endfunction

    ico_mid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mid_start),
        .a     (mid_a),
        .b     (mid_b),
        .done  (mid_done),
        .res   (mid_res)
    );

    always_comb
    begin
        row = ico_pkg::face_row(face_reg);
        c0  = corner_vec(row[0]);
        c1  = corner_vec(row[2]);
        c2  = corner_vec(row[1]);

        // pairs ab, ac, bc of the parent triangle at the current level
        case (cmd.mid_pair)
            2'd0:    begin mid_a = cmd.mid_lvl ? v0_reg : w0_reg; mid_b = cmd.mid_lvl ? v1_reg : w1_reg; end
            2'd1:    begin mid_a = cmd.mid_lvl ? v0_reg : w0_reg; mid_b = cmd.mid_lvl ? v2_reg : w2_reg; end
            default: begin mid_a = cmd.mid_lvl ? v1_reg : w1_reg; mid_b = cmd.mid_lvl ? v2_reg : w2_reg; end
        endcase

        case (cmd.depth)
            2'd0:
            begin
                case (cmd.vtx_pos)
                    2'd0:    leaf_slot = ico_pkg::SL_P0;
                    2'd1:    leaf_slot = ico_pkg::SL_P1;
                    default: leaf_slot = ico_pkg::SL_P2;
                endcase
                emit_vec = pick(leaf_slot, w0_reg, w1_reg, w2_reg, m0_reg, m1_reg, m2_reg);
            end
            2'd1:
            begin
                leaf_slot = ico_pkg::child_slot(cmd.child_k, cmd.vtx_pos);
                emit_vec = pick(leaf_slot, w0_reg, w1_reg, w2_reg, m0_reg, m1_reg, m2_reg);
            end
            default:
            begin
                leaf_slot = ico_pkg::child_slot(cmd.child_j, cmd.vtx_pos);
                emit_vec = pick(leaf_slot, v0_reg, v1_reg, v2_reg, n0_reg, n1_reg, n2_reg);
            end
        endcase

        case (cmd.comp)
            2'd0:    comp_val = emit_vec[0];
            2'd1:    comp_val = emit_vec[1];
            default: comp_val = emit_vec[2];
        endcase
        neg = comp_val[VW-1];
        mag = neg ? MAGW'(-comp_val) : MAGW'(comp_val);

        if (FRAC_BITS > 14)
            nwide = (NWW'(mag) + (NWW'(1) << (NSH_R - 1))) >> NSH_R;
        else
            nwide = NWW'(mag) << NSH_L;
        nq = neg ? -{1'b0, nwide[14:0]} : {1'b0, nwide[14:0]};

        prod = PRW'(mag) * PRW'(radius_reg);
        rsh  = (prod + (PRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        sat  = (rsh > PRW'(65536)) ? 17'd65536 : rsh[16:0];
        pq   = neg ? -{1'b0, sat} : {1'b0, sat};
    end

    assign stat.face_ok  = (in_data[4:0] < 5'(ico_pkg::FACE_COUNT));
    assign stat.mid_done = mid_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            face_reg   <= in_data[4:0];
            radius_reg <= in_data[20:5];
        end
        if (cmd.load_corners)
        begin
            w0_reg <= c0;
            w1_reg <= c1;
            w2_reg <= c2;
        end
        if (cmd.mid_store)
        begin
            case ({cmd.mid_lvl, cmd.mid_pair})
                3'b000:  m0_reg <= mid_res;
                3'b001:  m1_reg <= mid_res;
                3'b010:  m2_reg <= mid_res;
                3'b100:  n0_reg <= mid_res;
                3'b101:  n1_reg <= mid_res;
                default: n2_reg <= mid_res;
            endcase
        end
        if (cmd.copy_v)
        begin
            v0_reg <= pick(ico_pkg::child_slot(cmd.child_k, 2'd0),
                           w0_reg, w1_reg, w2_reg, m0_reg, m1_reg, m2_reg);
            v1_reg <= pick(ico_pkg::child_slot(cmd.child_k, 2'd1),
                           w0_reg, w1_reg, w2_reg, m0_reg, m1_reg, m2_reg);
            v2_reg <= pick(ico_pkg::child_slot(cmd.child_k, 2'd2),
                           w0_reg, w1_reg, w2_reg, m0_reg, m1_reg, m2_reg);
        end
        if (cmd.emit_calc)
        begin
            case (cmd.comp)
                2'd0:    begin nrm_reg[0] <= nq; pos_reg[0] <= pq; end
                2'd1:    begin nrm_reg[1] <= nq; pos_reg[1] <= pq; end
                default: begin nrm_reg[2] <= nq; pos_reg[2] <= pq; end
            endcase
        end
        if (cmd.emit_out)
        begin
            out_data_reg <= {2'b00, pos_reg[2], pos_reg[1], pos_reg[0],
                             nrm_reg[2], nrm_reg[1], nrm_reg[0]};
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

@@ src/ico_ctrl.sv @@
// Controller: walks the subdivision tree and sequences midpoints and vertex output.
module ico_ctrl #(
    parameter int MAX_LEVEL = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  ico_pkg::ico_stat_t  stat,
    output ico_pkg::ico_cmd_t   cmd
);

    ico_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0] level_reg;
    logic [1:0] depth_reg, depth_next;
    logic       lvl_reg, lvl_next;
    logic [1:0] pair_reg, pair_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] comp_reg, comp_next;
    logic       is_last;

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        lvl_next   = lvl_reg;
        pair_next  = pair_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        comp_next  = comp_reg;

        is_last = (pos_reg == 2'd2) && ((depth_reg == 2'd0) ||
                  ((k_reg == 2'd3) && ((depth_reg == 2'd1) || (j_reg == 2'd3))));

        cmd              = '0;
        cmd.mid_lvl      = lvl_reg;
        cmd.mid_pair     = pair_reg;
        cmd.depth        = depth_reg;
        cmd.child_k      = k_reg;
        cmd.child_j      = j_reg;
        cmd.vtx_pos      = pos_reg;
        cmd.comp         = comp_reg;
        cmd.last         = is_last;

        in_ready = (state_reg == ico_pkg::ST_IDLE);

        case (state_reg)
            ico_pkg::ST_IDLE:
            begin
                if (in_valid && stat.face_ok)
                begin
                    cmd.load_in = 1'b1;
                    depth_next  = (level_reg > 2'(MAX_LEVEL)) ? 2'(MAX_LEVEL) : level_reg;
                    state_next  = ico_pkg::ST_LOAD;
                end
            end
            ico_pkg::ST_LOAD:
            begin
                cmd.load_corners = 1'b1;
                lvl_next  = 1'b0;
                pair_next = 2'd0;
                k_next    = 2'd0;
                j_next    = 2'd0;
                pos_next  = 2'd0;
                comp_next = 2'd0;
                state_next = (depth_reg == 2'd0) ? ico_pkg::ST_EMIT_CALC
                                                 : ico_pkg::ST_MID_START;
            end
            ico_pkg::ST_MID_START:
            begin
                cmd.mid_start = 1'b1;
                state_next    = ico_pkg::ST_MID_WAIT;
            end
            ico_pkg::ST_MID_WAIT:
            begin
                if (stat.mid_done)
                begin
                    cmd.mid_store = 1'b1;
                    if (pair_reg != 2'd2)
                    begin
                        pair_next  = pair_reg + 2'd1;
                        state_next = ico_pkg::ST_MID_START;
                    end
                    else
                    begin
                        pair_next = 2'd0;
                        pos_next  = 2'd0;
                        comp_next = 2'd0;
                        if (!lvl_reg && (depth_reg == 2'd2))
                            state_next = ico_pkg::ST_COPY;
                        else
                            state_next = ico_pkg::ST_EMIT_CALC;
                    end
                end
            end
            ico_pkg::ST_COPY:
            begin
                cmd.copy_v = 1'b1;
                lvl_next   = 1'b1;
                state_next = ico_pkg::ST_MID_START;
            end
            ico_pkg::ST_EMIT_CALC:
            begin
                cmd.emit_calc = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = ico_pkg::ST_EMIT_OUT;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ico_pkg::ST_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_out = 1'b1;
                    if (pos_reg != 2'd2)
                    begin
                        pos_next   = pos_reg + 2'd1;
                        state_next = ico_pkg::ST_EMIT_CALC;
                    end
                    else
                    begin
                        pos_next = 2'd0;
                        if (depth_reg == 2'd0)
                        begin
                            state_next = ico_pkg::ST_IDLE;
                        end
                        else if (depth_reg == 2'd1)
                        begin
                            if (k_reg == 2'd3)
                            begin
                                state_next = ico_pkg::ST_IDLE;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                state_next = ico_pkg::ST_EMIT_CALC;
                            end
                        end
                        else if (j_reg != 2'd3)
                        begin
                            j_next     = j_reg + 2'd1;
                            state_next = ico_pkg::ST_EMIT_CALC;
                        end
                        else
                        begin
                            j_next = 2'd0;
                            if (k_reg == 2'd3)
                            begin
                                state_next = ico_pkg::ST_IDLE;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                state_next = ico_pkg::ST_COPY;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ico_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ico_pkg::ST_IDLE;
            level_reg <= 2'd2;
            depth_reg <= 2'd0;
            lvl_reg   <= 1'b0;
            pair_reg  <= 2'd0;
            k_reg     <= 2'd0;
            j_reg     <= 2'd0;
            pos_reg   <= 2'd0;
            comp_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            lvl_reg   <= lvl_next;
            pair_reg  <= pair_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            pos_reg   <= pos_next;
            comp_reg  <= comp_next;
            if (cfg_wr_en)
            begin
                level_reg <= cfg_wr_data;
            end
        end
    end

endmodule

@@ src/icosphere_face_tessellator_unit.sv @@
// Top level of the icosphere face tessellator: controller, datapath and stream ports.
//
// Usage:
//   The slave stream takes one request per face: the face index of the
//   icosahedron (0..19) and a radius in unsigned Q8.8. A face index of 20 or
//   more is accepted and dropped without any output.
//   The master stream returns one request per vertex: the unit normal in
//   Q1.14 and the position (normal times radius) in Q8.8, saturated to
//   +/-256.0. tlast marks the final vertex of the face.
//   The user writes subdivision_level through cfg_wr_en/cfg_wr_data only
//   while idle; the block itself does not enforce this. Reset sets it to
//   2. Values above MAX_LEVEL are clamped.
// Sequencing (FRAC_BITS = 14): each edge midpoint runs in the shared
//   midpoint unit: start, squaring of the three components, 17 square-root
//   steps, setup, 15 quotient bits of three parallel restoring dividers,
//   done. Level 0: 3 vertices per face; level 1: 3 midpoints, 12 vertices;
//   level 2: 15 midpoints, 4 child copies, 48 vertices. A new face is
//   taken once the last vertex sits in the output register.
// Reset clears the controller and the output valid flag. When the receiver
// stalls, the finished vertex holds in the output register and the next
// vertex waits in the datapath until it is taken.
module icosphere_face_tessellator_unit #(
    parameter int MAX_LEVEL = 2,
    parameter int FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // fields from bit 0: face_index[4:0], radius[20:5], zero pad
    input  logic [ico_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // fields from bit 0: normal_x, normal_y, normal_z (16 each),
    // pos_x, pos_y, pos_z (18 each), zero pad
    output logic [ico_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_wr_data
);

    ico_pkg::ico_cmd_t  cmd;
    ico_pkg::ico_stat_t stat;

    // Sequence the tree walk: midpoint requests, child copies, vertex output
    ico_ctrl #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Hold vertices, run midpoints, scale and register each output vertex
    ico_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
